### sv/dpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants
// Frame geometry, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dpc_pkg;
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int CNT_W   = 19;
  localparam int SUMXY_W = 47;
  localparam int SUMZ_W  = 35;
  localparam int POS_W   = 28;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);

  localparam logic [1:0] REG_CENTER_COL = 2'd0;
  localparam logic [1:0] REG_CENTER_ROW = 2'd1;
  localparam logic [1:0] REG_INV_FOCAL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_POINT, ST_DIV_START, ST_DIV, ST_CENT
  } state_t;

  typedef struct packed {
    logic capture;   // latch input pixel
    logic mul1;      // first product stage
    logic mul2;      // second product stage and accumulate
    logic div_start; // start centroid division
    logic frame_clr; // clear sums and counters
    logic advance;   // advance pixel position
  } cmd_t;

  typedef struct packed {
    logic valid_px;
    logic end_frame;
    logic div_done;
  } stat_t;
endpackage

### sv/dpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_datapath: projection, accumulation and centroid division
// Two-stage multiply per point, running sums, and a restoring divider that
// produces all three centroid quotients one bit a cycle.
// ----------------------------------------------------------------------------
module dpc_datapath import dpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t stat,
  input  logic [9:0]  center_col,
  input  logic [9:0]  center_row,
  input  logic [15:0] inv_focal,
  input  logic [15:0] depth,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  output logic signed [POS_W-1:0] pt_x,
  output logic signed [POS_W-1:0] pt_y,
  output logic [15:0] pt_z,
  output logic [7:0]  pt_r,
  output logic [7:0]  pt_g,
  output logic [7:0]  pt_b,
  output logic signed [POS_W-1:0] c_x,
  output logic signed [POS_W-1:0] c_y,
  output logic [15:0] c_z,
  output logic        c_valid
);
  localparam int DIV_W = SUMXY_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  logic [COL_W-1:0] column_index;
  logic [ROW_W-1:0] row_index;
  logic [CNT_W-1:0] point_count;
  logic signed [SUMXY_W-1:0] sum_x, sum_y;
  logic [SUMZ_W-1:0] sum_z;

  logic [10:0] dx_mag, dy_mag;
  logic        dx_neg, dy_neg;
  logic [26:0] px_mag, py_mag;   // |d| * z
  logic [42:0] qx_mag, qy_mag;   // times inv_focal, Q.16

  // Offsets from the principal point
  logic signed [11:0] dx, dy;
  always_comb begin
    dx = $signed({2'b00, center_col}) - $signed({2'b00, column_index});
    dy = $signed({2'b00, center_row}) - $signed({3'b000, row_index});
  end

  // Capture pixel and offset magnitudes
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pt_z <= depth;
      pt_r <= red;
      pt_g <= green;
      pt_b <= blue;
      dx_neg <= dx[11];
      dy_neg <= dy[11];
      dx_mag <= dx[11] ? 11'(-dx) : dx[10:0];
      dy_mag <= dy[11] ? 11'(-dy) : dy[10:0];
    end
    if (cmd.mul1) begin
      px_mag <= {16'd0, dx_mag} * {11'd0, pt_z};
      py_mag <= {16'd0, dy_mag} * {11'd0, pt_z};
    end
    if (cmd.mul2) begin
      qx_mag <= {16'd0, px_mag} * {27'd0, inv_focal};
      qy_mag <= {16'd0, py_mag} * {27'd0, inv_focal};
    end
  end

  logic [POS_W-1:0] vx, vy;
  always_comb begin
    vx = {1'b0, qx_mag[42:16]};
    vy = {1'b0, qy_mag[42:16]};
    pt_x = dx_neg ? -$signed(vx) : $signed(vx);
    pt_y = dy_neg ? -$signed(vy) : $signed(vy);
  end

  logic acc_pend;
  always_ff @(posedge clk) begin
    if (rst) acc_pend <= 1'b0;
    else acc_pend <= cmd.mul2 && stat.valid_px;
  end

  // Position counters and sums
  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clr) begin
      column_index <= '0;
      row_index <= '0;
      point_count <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end else begin
      if (cmd.advance) begin
        if (column_index >= LAST_COL) begin
          column_index <= '0;
          row_index <= row_index + 1'b1;
        end else begin
          column_index <= column_index + 1'b1;
        end
      end
      if (cmd.mul2 && stat.valid_px) begin
        if (point_count != COUNT_MAX) point_count <= point_count + 1'b1;
      end
      // Accumulate the point finished in the previous cycle
      if (acc_pend) begin
        sum_x <= sum_x + SUMXY_W'(pt_x);
        sum_y <= sum_y + SUMXY_W'(pt_y);
        sum_z <= sum_z + SUMZ_W'(pt_z);
      end
    end
  end

  // Restoring divider: magnitudes of three dividends over the count
  logic [DIV_W-1:0] nx, ny, nz;
  logic [CNT_W:0]   rx, ry, rz;
  logic [CNT_W-1:0] dv;
  logic             sx, sy, busy;
  logic [DCNT_W-1:0] dcnt;
  logic [CNT_W:0] tx, ty, tz;

  always_comb begin
    tx = {rx[CNT_W-1:0], nx[DIV_W-1]};
    ty = {ry[CNT_W-1:0], ny[DIV_W-1]};
    tz = {rz[CNT_W-1:0], nz[DIV_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.div_start) begin
      busy <= 1'b1;
      dcnt <= DCNT_W'(DIV_W);
      dv <= point_count;
      c_valid <= (point_count != '0);
      sx <= sum_x[SUMXY_W-1];
      sy <= sum_y[SUMXY_W-1];
      nx <= sum_x[SUMXY_W-1] ? DIV_W'(-sum_x) : DIV_W'(sum_x);
      ny <= sum_y[SUMXY_W-1] ? DIV_W'(-sum_y) : DIV_W'(sum_y);
      nz <= DIV_W'(sum_z);
      rx <= '0;
      ry <= '0;
      rz <= '0;
    end else if (busy) begin
      // One quotient bit per cycle, shifted into the dividend registers
      if (tx >= {1'b0, dv}) begin
        rx <= tx - {1'b0, dv}; nx <= {nx[DIV_W-2:0], 1'b1};
      end else begin
        rx <= tx; nx <= {nx[DIV_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv}) begin
        ry <= ty - {1'b0, dv}; ny <= {ny[DIV_W-2:0], 1'b1};
      end else begin
        ry <= ty; ny <= {ny[DIV_W-2:0], 1'b0};
      end
      if (tz >= {1'b0, dv}) begin
        rz <= tz - {1'b0, dv}; nz <= {nz[DIV_W-2:0], 1'b1};
      end else begin
        rz <= tz; nz <= {nz[DIV_W-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
      if (dcnt == DCNT_W'(1)) busy <= 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    stat.valid_px = (pt_z != 16'd0);
    stat.end_frame = (column_index >= LAST_COL) && (row_index >= LAST_ROW);
    stat.div_done = !busy;
  end

  // Centroid values; an empty frame divides by zero, so force zero there
  always_comb begin
    c_x = !c_valid ? '0 : (sx ? -$signed(nx[POS_W-1:0]) : $signed(nx[POS_W-1:0]));
    c_y = !c_valid ? '0 : (sy ? -$signed(ny[POS_W-1:0]) : $signed(ny[POS_W-1:0]));
    c_z = c_valid ? nz[15:0] : 16'd0;
  end
endmodule

### sv/dpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_ctrl: sequencing of one pixel
// Capture, two multiply steps, point output for a nonzero depth, then the
// centroid division and output at the end of a frame.
// ----------------------------------------------------------------------------
module dpc_ctrl import dpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_sel_cent,
  output logic  out_last,
  output cmd_t  cmd,
  input  stat_t stat
);
  state_t state, state_next;
  logic   ef, ef_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ef <= 1'b0;
    end else begin
      state <= state_next;
      ef <= ef_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    ef_next = ef;
    case (state)
      ST_IDLE: if (in_valid) begin
        state_next = ST_MUL1;
        ef_next = stat.end_frame;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: if (stat.valid_px) state_next = ST_POINT;
               else if (ef) state_next = ST_DIV_START;
               else state_next = ST_IDLE;
      ST_POINT: if (out_ready) state_next = ef ? ST_DIV_START : ST_IDLE;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV: if (stat.div_done) state_next = ST_CENT;
      ST_CENT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_sel_cent = 1'b0;
    out_last = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
        cmd.advance = in_valid && !stat.end_frame;
      end
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_POINT: begin
        out_valid = 1'b1;
        out_last = !ef;
      end
      // Sums are settled here, including the last point of the frame
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV: ;
      ST_CENT: begin
        out_valid = 1'b1;
        out_sel_cent = 1'b1;
        out_last = 1'b1;
        cmd.frame_clr = out_ready;
      end
      default: ;
    endcase
  end
endmodule

### sv/depth_to_point_cloud_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_point_cloud_centroid: pinhole backprojection with frame centroid
// Raster pixels in, 3D points out, and a centroid after each frame.
// ----------------------------------------------------------------------------
//   channel | handshake          | payload
//   pixel   | in_valid/in_ready  | depth, blue, green, red
//   result  | out_valid/out_ready| is_centroid .. last
//   config  | cfg_we             | cfg_index, cfg_data
// A pixel passes through capture, two multiply steps and, for a nonzero depth,
// a point output that may stall; the next pixel waits until it is done. The
// last pixel of a frame then starts the bit-serial divider for the centroid.
// Reset is synchronous; the block takes no pixel while a result waits.
module depth_to_point_cloud_centroid import dpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] depth,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  output logic out_valid,
  input  logic out_ready,
  output logic is_centroid,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic [15:0] pos_z,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic centroid_valid,
  output logic last,
  input  logic cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [9:0]  center_col, center_row;
  logic [15:0] inv_focal;
  cmd_t  cmd;
  stat_t stat;
  logic  sel_cent;
  logic signed [POS_W-1:0] pt_x, pt_y, c_x, c_y;
  logic [15:0] pt_z, c_z;
  logic [7:0]  pt_r, pt_g, pt_b;
  logic        c_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= 10'd320;
      center_row <= 10'd240;
      inv_focal <= 16'd29136;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_COL: center_col <= cfg_data[9:0];
        REG_CENTER_ROW: center_row <= cfg_data[9:0];
        REG_INV_FOCAL:  inv_focal <= cfg_data;
        default: ;
      endcase
    end
  end

  dpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_sel_cent(sel_cent), .out_last(last), .cmd, .stat
  );

  dpc_datapath u_dp (
    .clk, .rst, .cmd, .stat, .center_col, .center_row, .inv_focal,
    .depth, .blue, .green, .red, .pt_x, .pt_y, .pt_z, .pt_r, .pt_g, .pt_b,
    .c_x, .c_y, .c_z, .c_valid
  );

  // Select point or centroid payload
  always_comb begin
    is_centroid = sel_cent;
    pos_x = sel_cent ? c_x : pt_x;
    pos_y = sel_cent ? c_y : pt_y;
    pos_z = sel_cent ? c_z : pt_z;
    red_out = sel_cent ? 8'd0 : pt_r;
    green_out = sel_cent ? 8'd0 : pt_g;
    blue_out = sel_cent ? 8'd0 : pt_b;
    centroid_valid = sel_cent && c_valid;
  end
endmodule

### tb/tb_depth_to_point_cloud_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_to_point_cloud_centroid: self-checking bench for the backprojector
// Drives raster pixels with random gaps and output stalls, predicts every
// point and frame centroid in a behavioral model, and checks each result in
// order. Covers a directed table and random pixels under several register
// settings.
// ----------------------------------------------------------------------------
module tb_depth_to_point_cloud_centroid;
  import dpc_pkg::*;

  typedef struct packed {
    logic              is_c;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [15:0]       z;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic              cv;
    logic              lst;
  } point_res_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [15:0] val;
    logic [15:0] d;
    logic [7:0]  b, g, r;
    bit          typed;
    point_res_t  res;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [15:0] depth;
  logic [7:0] blue, green, red;
  logic out_valid, out_ready;
  logic is_centroid;
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic [15:0] pos_z;
  logic [7:0] red_out, green_out, blue_out;
  logic centroid_valid, last;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  depth_to_point_cloud_centroid u_dut (.*);

  // model state and registers
  logic [COL_W-1:0] m_col;
  logic [ROW_W-1:0] m_row;
  logic [CNT_W-1:0] m_cnt;
  longint           m_sx, m_sy;
  longint unsigned  m_sz;
  logic [9:0]       k_ccol, k_crow;
  logic [15:0]      k_invf;

  point_res_t pending[$];
  stim_row_t  tbl[$];
  int  errors;
  int  idle_cyc;
  int  stall_left;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // signed offset times depth times Q0.16 reciprocal focal, toward zero
  function automatic longint backproject(logic [9:0] centre, logic [9:0] p,
                                         logic [15:0] z);
    longint dlt, v;
    longint unsigned mag;
    dlt = longint'(centre) - longint'(p);
    mag = (dlt < 0) ? -dlt : dlt;
    v = longint'((mag * z * k_invf) >> 16);
    return (dlt < 0) ? -v : v;
  endfunction

  // predict the results of one accepted pixel and advance the raster
  task automatic expect_pixel(logic [15:0] d, logic [7:0] b, logic [7:0] g,
                              logic [7:0] r, bit typed, point_res_t tres);
    bit ecol, efr;
    longint x, y, c;
    point_res_t o;
    ecol = (m_col >= LAST_COL);
    efr = ecol && (m_row >= LAST_ROW);
    if (d != 0) begin
      x = backproject(k_ccol, m_col, d);
      y = backproject(k_crow, {1'b0, m_row}, d);
      o = '{1'b0, x[POS_W-1:0], y[POS_W-1:0], d, r, g, b, 1'b0, !efr};
      pending.insert(pending.size(), typed ? tres : o);
      if (m_cnt != COUNT_MAX) m_cnt++;
      m_sx += x;
      m_sy += y;
      m_sz += d;
    end
    if (efr) begin
      if (m_cnt != 0) begin
        c = longint'(m_cnt);
        x = m_sx / c;
        y = m_sy / c;
        o = '{1'b1, x[POS_W-1:0], y[POS_W-1:0], 16'(m_sz / m_cnt),
              8'd0, 8'd0, 8'd0, 1'b1, 1'b1};
      end else begin
        o = '{1'b1, '0, '0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};
      end
      pending.insert(pending.size(), o);
      m_col = '0;
      m_row = '0;
      m_cnt = '0;
      m_sx = 0;
      m_sy = 0;
      m_sz = 0;
    end else if (ecol) begin
      m_col = '0;
      m_row++;
    end else begin
      m_col++;
    end
  endtask

  // present one item and hold it until accepted
  task automatic send_pixel(int gap, logic [15:0] d, logic [7:0] b,
                            logic [7:0] g, logic [7:0] r, bit typed,
                            point_res_t tres);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    depth <= d;
    blue <= b;
    green <= g;
    red <= r;
    do @(posedge clk); while (!in_ready);
    expect_pixel(d, b, g, r, typed, tres);
  endtask

  // drain results and let the block settle before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_COL: k_ccol = val[9:0];
      REG_CENTER_ROW: k_crow = val[9:0];
      REG_INV_FOCAL:  k_invf = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] ccol, logic [15:0] crow,
                          logic [15:0] invf);
    wait_idle();
    write_reg(REG_CENTER_COL, ccol);
    write_reg(REG_CENTER_ROW, crow);
    write_reg(REG_INV_FOCAL, invf);
  endtask

  function automatic logic [15:0] rand_depth();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return 16'd0;
    if (sel < 30) return 16'hFFFF;
    if (sel < 40) return 16'($urandom_range(1, 15));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic void add_px(logic [15:0] d, logic [7:0] b, logic [7:0] g,
                                 logic [7:0] r);
    stim_row_t t;
    t = '{1'b0, REG_CENTER_COL, 16'd0, d, b, g, r, 1'b0, '0};
    tbl.insert(tbl.size(), t);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [15:0] val);
    stim_row_t t;
    t = '{1'b1, idx, val, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0};
    tbl.insert(tbl.size(), t);
  endfunction

  function automatic void check_field(string name, logic [POS_W-1:0] e,
                                      logic [POS_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  // result sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    point_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual x=%h y=%h z=%h",
                 $time, pos_x, pos_y, pos_z);
        errors++;
      end else begin
        e = pending.pop_front();
        check_field("is_centroid", POS_W'(e.is_c), POS_W'(is_centroid));
        check_field("pos_x", e.x, pos_x);
        check_field("pos_y", e.y, pos_y);
        check_field("pos_z", POS_W'(e.z), POS_W'(pos_z));
        check_field("red_out", POS_W'(e.r), POS_W'(red_out));
        check_field("green_out", POS_W'(e.g), POS_W'(green_out));
        check_field("blue_out", POS_W'(e.b), POS_W'(blue_out));
        check_field("centroid_valid", POS_W'(e.cv), POS_W'(centroid_valid));
        check_field("last", POS_W'(e.lst), POS_W'(last));
      end
    end
  end

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cyc = 0;
    else
      idle_cyc++;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("tb_depth_to_point_cloud_centroid: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t t;
    point_res_t none;
    errors = 0;
    idle_cyc = 0;
    none = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    depth <= '0;
    blue <= '0;
    green <= '0;
    red <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    m_col = '0;
    m_row = '0;
    m_cnt = '0;
    m_sx = 0;
    m_sy = 0;
    m_sz = 0;
    k_ccol = 10'd320;
    k_crow = 10'd240;
    k_invf = 16'd29136;

    // directed table
    add_px(16'd0, 8'hFF, 8'hFF, 8'hFF);
    add_px(16'd1, 8'h00, 8'h00, 8'h00);
    add_px(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    add_px(16'h8000, 8'h55, 8'hAA, 8'h0F);
    add_cfg(REG_INV_FOCAL, 16'd0);
    // zero reciprocal focal: coordinates collapse to zero
    t = '{1'b0, REG_CENTER_COL, 16'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{1'b0, '0, '0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1}};
    tbl.insert(tbl.size(), t);
    add_cfg(REG_INV_FOCAL, 16'hFFFF);
    add_cfg(REG_CENTER_COL, 16'd1023);
    add_cfg(REG_CENTER_ROW, 16'd1023);
    add_px(16'hFFFF, 8'h12, 8'h34, 8'h56);
    add_cfg(REG_CENTER_COL, 16'd0);
    add_cfg(REG_CENTER_ROW, 16'd0);
    add_px(16'hFFFF, 8'hA5, 8'h5A, 8'hC3);
    // out-of-range register index is ignored
    add_cfg(REG_UNUSED, 16'hFFFF);
    add_px(16'h1234, 8'h01, 8'h80, 8'hFE);
    add_cfg(REG_INV_FOCAL, 16'd1);
    add_px(16'hFFFF, 8'h7F, 8'hF7, 8'h3C);
    add_px(16'd0, 8'h00, 8'h00, 8'h00);
    add_cfg(REG_CENTER_COL, 16'd320);
    add_cfg(REG_CENTER_ROW, 16'd240);
    add_cfg(REG_INV_FOCAL, 16'd29136);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tbl[i]) begin
      if (tbl[i].is_cfg) begin
        wait_idle();
        write_reg(tbl[i].idx, tbl[i].val);
      end else begin
        send_pixel(pick_gap(), tbl[i].d, tbl[i].b, tbl[i].g, tbl[i].r,
                   tbl[i].typed, tbl[i].res);
      end
    end

    // random pixels under several register settings
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_regs(16'd0, 16'd1023, 16'hFFFF);
        1: set_regs(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                    16'($urandom_range(1, 65535)));
        2: set_regs(16'd1023, 16'd0, 16'd1);
        default: set_regs(16'd320, 16'd240, 16'd29136);
      endcase
      repeat (475)
        send_pixel(pick_gap(), rand_depth(), 8'($urandom), 8'($urandom),
                   8'($urandom), 1'b0, none);
    end

    // drain and report
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("tb_depth_to_point_cloud_centroid: clean");
    else
      $display("tb_depth_to_point_cloud_centroid: errors");
    $finish;
  end
endmodule
